@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl modules
// both expect clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASRT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define ASRT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/asrb_pkg.sv @@
// ----------------------------------------------------------------------------
// asrb_pkg
// Shared types, codes and ring pointer helpers for the audio sample ring bridge.
// ----------------------------------------------------------------------------
`default_nettype none

package asrb_pkg;

  // ring geometry
  localparam int RING_DEPTH = 32768;
  localparam int RING_SPAN  = 2 * RING_DEPTH;
  localparam int PTR_W      = $clog2(RING_SPAN);
  localparam int ADDR_W     = $clog2(RING_DEPTH);

  localparam int SAMPLE_W = 16;
  localparam int OP_W     = 3;
  localparam int VOL_W    = 7;
  localparam int REG_IDX_W = 2;

  typedef logic [PTR_W-1:0]           ptr_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [OP_W-1:0]            op_t;

  // opcodes
  localparam op_t OP_PUSH    = 3'd0;
  localparam op_t OP_TICK    = 3'd1;
  localparam op_t OP_CAPTURE = 3'd2;
  localparam op_t OP_PULL    = 3'd3;
  localparam op_t OP_CLR_PB  = 3'd4;
  localparam op_t OP_CLR_CAP = 3'd5;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_VOLUME  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PLAY_EN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REC_EN  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MUTE    = 2'd3;

  // volume limits
  localparam logic [VOL_W-1:0] VOL_MIN   = 7'd10;
  localparam logic [VOL_W-1:0] VOL_MAX   = 7'd100;
  localparam logic [VOL_W-1:0] VOL_RESET = 7'd100;

  // divide by 100: ceil(2^32 / 100), exact for magnitudes below 2^30
  localparam int            PROD_W    = 24;
  localparam int            MAG_W     = 22;
  localparam int            DIV_SHIFT = 32;
  localparam int            RECIP_W   = 26;
  localparam int            DIVP_W    = DIV_SHIFT + SAMPLE_W;
  localparam logic [RECIP_W-1:0] RECIP_K = 26'd42949673;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic rd;
    logic fin;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;
  } status_t;

  // pointer step, wrapping at twice the depth
  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    r = (p == PTR_W'(RING_SPAN - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  // entries held between two pointers
  function automatic ptr_t ptr_fill(input ptr_t wp, input ptr_t rp);
    ptr_t r;
    r = (wp >= rp) ? wp - rp : wp + PTR_W'(RING_SPAN) - rp;
    return r;
  endfunction

  // storage address of a pointer
  function automatic addr_t ptr_idx(input ptr_t p);
    ptr_t t;
    t = (p >= PTR_W'(RING_DEPTH)) ? p - PTR_W'(RING_DEPTH) : p;
    return t[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/asrb_ram.sv @@
// ----------------------------------------------------------------------------
// asrb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module asrb_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/asrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// asrb_ctrl
// Sequencer: takes one transfer at a time and steps the datapath through
// scale, ring read and finish phases.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module asrb_ctrl
  import asrb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  input  wire op_t     in_op,
  output logic         in_tready,
  input  wire status_t st,
  output cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       in_fire;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // commands
  always_comb begin
    cmd.load = in_fire;
    cmd.mul  = (state_r == S_MUL);
    cmd.div  = (state_r == S_DIV);
    cmd.rd   = (state_r == S_RD);
    cmd.fin  = (state_r == S_FIN) && st.slot_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            OP_PUSH:          state_nxt = S_MUL;
            OP_TICK, OP_PULL: state_nxt = S_RD;
            default:          state_nxt = S_FIN;
          endcase
        end
      end
      S_MUL: state_nxt = S_DIV;
      S_DIV: state_nxt = S_FIN;
      S_RD:  state_nxt = S_FIN;
      S_FIN: begin
        if (st.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASRT_NXT(a_accept_leaves_idle, in_fire, state_r != S_IDLE, "accepted item did not start")
  `ASRT_NXT(a_fin_returns_idle, cmd.fin, state_r == S_IDLE, "finish did not return to idle")
  `ASRT_IMP(a_fin_needs_slot, state_r == S_FIN && !st.slot_free, !cmd.fin,
            "finish issued while result slot busy")

endmodule

`default_nettype wire

@@ rtl/asrb_dp.sv @@
// ----------------------------------------------------------------------------
// asrb_dp
// Datapath: config registers, volume scaling, ring pointers, the two sample
// RAMs and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module asrb_dp
  import asrb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output status_t                   st,
  input  wire op_t                  in_op,
  input  wire sample_t              in_sample,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [VOL_W-1:0]     cfg_wdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [79:0]               out_tdata,
  output logic [1:0]                out_tuser
);

  // config registers
  logic [VOL_W-1:0] vol_r;
  logic [VOL_W-1:0] vol_nxt;
  logic             play_en_r;
  logic             rec_en_r;
  logic             mute_r;

  // item registers
  op_t              op_r;
  sample_t          sample_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [DIVP_W-1:0]        recip_r;
  logic                     neg_r;

  // ring pointers
  ptr_t pb_wp_r, pb_rp_r, cp_wp_r, cp_rp_r;
  ptr_t pb_wp_nxt, pb_rp_nxt, cp_wp_nxt, cp_rp_nxt;

  // result register
  logic        out_valid_r;
  logic [79:0] out_data_r;
  logic [1:0]  out_user_r;

  logic signed [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0]        prod_abs;
  logic [MAG_W-1:0]         mag;
  logic [SAMPLE_W-1:0]      quot;
  sample_t                  scaled;

  ptr_t    pb_fill, cp_fill;
  logic    pb_full, pb_empty, cp_full, cp_empty;
  logic    tick_take, pull_take;
  logic    pb_we, cp_we;
  sample_t pb_rdata, cp_rdata;

  logic    res_accepted, res_valid;
  sample_t res_tick, res_got;
  logic [15:0] res_space, res_count;

  // volume saturation on write
  always_comb begin
    priority if (cfg_wdata < VOL_MIN) begin
      vol_nxt = VOL_MIN;
    end else if (cfg_wdata > VOL_MAX) begin
      vol_nxt = VOL_MAX;
    end else begin
      vol_nxt = cfg_wdata;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r     <= VOL_RESET;
      play_en_r <= 1'b0;
      rec_en_r  <= 1'b0;
      mute_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VOLUME:  vol_r     <= vol_nxt;
        REG_PLAY_EN: play_en_r <= cfg_wdata[0];
        REG_REC_EN:  rec_en_r  <= cfg_wdata[0];
        REG_MUTE:    mute_r    <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  // scaling: sample * volume, then divide by 100 via reciprocal
  assign prod_nxt = PROD_W'(sample_r) * $signed(PROD_W'({1'b0, vol_r}));
  assign prod_abs = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign mag      = prod_abs[MAG_W-1:0];
  assign quot     = recip_r[DIV_SHIFT +: SAMPLE_W];
  assign scaled   = neg_r ? sample_t'(-quot) : sample_t'(quot);

  // item capture and arithmetic stages
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      sample_r <= in_sample;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.div) begin
      recip_r <= DIVP_W'(mag) * DIVP_W'(RECIP_K);
      neg_r   <= prod_r[PROD_W-1];
    end
  end

  // ring levels
  assign pb_fill   = ptr_fill(pb_wp_r, pb_rp_r);
  assign cp_fill   = ptr_fill(cp_wp_r, cp_rp_r);
  assign pb_full   = (pb_fill >= PTR_W'(RING_DEPTH));
  assign cp_full   = (cp_fill >= PTR_W'(RING_DEPTH));
  assign pb_empty  = (pb_fill == '0);
  assign cp_empty  = (cp_fill == '0);
  assign tick_take = play_en_r && !mute_r && !pb_empty;
  assign pull_take = !cp_empty;

  assign pb_we = cmd.fin && (op_r == OP_PUSH) && !pb_full;
  assign cp_we = cmd.fin && (op_r == OP_CAPTURE) && rec_en_r && !cp_full;

  // sample rings
  asrb_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_pb_ram (
    .clk   (clk),
    .we    (pb_we),
    .waddr (ptr_idx(pb_wp_r)),
    .wdata (scaled),
    .re    (cmd.rd && (op_r == OP_TICK)),
    .raddr (ptr_idx(pb_rp_r)),
    .rdata (pb_rdata)
  );

  asrb_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_cp_ram (
    .clk   (clk),
    .we    (cp_we),
    .waddr (ptr_idx(cp_wp_r)),
    .wdata (sample_r),
    .re    (cmd.rd && (op_r == OP_PULL)),
    .raddr (ptr_idx(cp_rp_r)),
    .rdata (cp_rdata)
  );

  // pointer updates and result fields for the finishing item
  always_comb begin
    pb_wp_nxt    = pb_wp_r;
    pb_rp_nxt    = pb_rp_r;
    cp_wp_nxt    = cp_wp_r;
    cp_rp_nxt    = cp_rp_r;
    res_accepted = 1'b0;
    res_valid    = 1'b0;
    res_tick     = '0;
    res_got      = '0;
    unique case (op_r)
      OP_PUSH: begin
        if (!pb_full) begin
          pb_wp_nxt    = ptr_inc(pb_wp_r);
          res_accepted = 1'b1;
        end
      end
      OP_TICK: begin
        if (tick_take) begin
          pb_rp_nxt = ptr_inc(pb_rp_r);
          res_tick  = pb_rdata;
        end
      end
      OP_CAPTURE: begin
        if (rec_en_r && !cp_full) begin
          cp_wp_nxt    = ptr_inc(cp_wp_r);
          res_accepted = 1'b1;
        end
      end
      OP_PULL: begin
        if (pull_take) begin
          cp_rp_nxt = ptr_inc(cp_rp_r);
          res_got   = cp_rdata;
          res_valid = 1'b1;
        end
      end
      OP_CLR_PB: begin
        pb_wp_nxt = '0;
        pb_rp_nxt = '0;
      end
      OP_CLR_CAP: begin
        cp_wp_nxt = '0;
        cp_rp_nxt = '0;
      end
      default: ;
    endcase
    res_space = 16'(PTR_W'(RING_DEPTH) - ptr_fill(pb_wp_nxt, pb_rp_nxt));
    res_count = 16'(ptr_fill(cp_wp_nxt, cp_rp_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_wp_r <= '0;
      pb_rp_r <= '0;
      cp_wp_r <= '0;
      cp_rp_r <= '0;
    end else if (cmd.fin) begin
      pb_wp_r <= pb_wp_nxt;
      pb_rp_r <= pb_rp_nxt;
      cp_wp_r <= cp_wp_nxt;
      cp_rp_r <= cp_rp_nxt;
    end
  end

  // result register, freed by an output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data_r <= {res_count, res_space, res_got, res_tick, res_tick};
      out_user_r <= {res_valid, res_accepted};
    end
  end

  assign st.slot_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_user_r;

  `ASRT_IMP(a_fill_bound, 1'b1,
            pb_fill <= PTR_W'(RING_DEPTH) && cp_fill <= PTR_W'(RING_DEPTH),
            "ring fill above depth")
  `ASRT_NXT(a_push_grows, pb_we, pb_fill == $past(pb_fill) + PTR_W'(1),
            "stored push did not grow playback fill")
  `ASRT_IMP(a_single_write, pb_we || cp_we, !(pb_we && cp_we),
            "both rings written by one item")

endmodule

`default_nettype wire

@@ rtl/audio_sample_ring_bridge.sv @@
// ----------------------------------------------------------------------------
// audio_sample_ring_bridge
// Playback and capture sample rings with volume scaling, one command per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer; in_tuser carries the opcode, in_tdata the
//           sample (push playback, frame tick, capture frame, pull capture,
//           clear playback, clear capture).
//   out_* : exactly one result per command, in command order.
//   cfg_* : register writes (volume, play enable, record enable, mute), taken
//           on any cycle cfg_we is high, meant for use while the block is idle.
//   Items are handled one at a time by a small sequencer. A push steps through
//   multiply, reciprocal divide and the finishing ring write; tick and pull
//   pass a read step since the ring RAM read is registered; the others go
//   straight to the finishing step. The result is registered at the finishing
//   step and appears in the next cycle.
//   The result sits in an output register; while the receiver stalls the next
//   command is still taken and worked up to its finishing step, which waits
//   for the register to free.
//   Synchronous reset empties both rings and restores register defaults; the
//   ring RAMs are not cleared, no entry is read before it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_sample_ring_bridge
  import asrb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [15:0]          in_tdata,   // sample_in[15:0]
  input  wire logic [2:0]           in_tuser,   // opcode[2:0]
  // result channel
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [79:0]               out_tdata,  // left_out, right_out,
                                                // captured_sample, playback_space,
                                                // capture_count (16 bits each)
  output logic [1:0]                out_tuser,  // accepted, captured_valid
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [VOL_W-1:0]     cfg_wdata
);

  cmd_t    cmd;
  status_t st;

  // sequencer
  asrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath
  asrb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_op      (in_tuser),
    .in_sample  (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

@@ verif/audio_sample_ring_bridge_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_sample_ring_bridge_tb
// Streams commands into the sample ring bridge and checks every result against
// a behavioral copy of the two rings and the register set. A directed opening
// covers empty, muted, disabled, clear and volume saturation cases. Random
// phases with fresh settings follow, with random idling on both channels.
// ----------------------------------------------------------------------------

module audio_sample_ring_bridge_tb;
  import asrb_pkg::*;

  localparam int   CYCLE_LIMIT = 600_000;
  localparam int   PERCENT     = 100;
  localparam int   PHASES      = 6;
  localparam int   PHASE_ITEMS = 225;
  localparam op_t  OP_SPARE_6  = 3'd6;
  localparam op_t  OP_SPARE_7  = 3'd7;

  typedef struct {
    op_t     op;
    sample_t sample;
  } bridge_cmd_t;

  typedef struct packed {
    logic        accepted;
    logic        captured_valid;
    sample_t     left;
    sample_t     right;
    sample_t     captured;
    logic [15:0] space;
    logic [15:0] count;
  } bridge_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // sample_in[15:0]
  logic [2:0]  in_tuser = '0;   // opcode[2:0]

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;       // left_out, right_out, captured_sample,
                                // playback_space, capture_count
  logic [1:0]  out_tuser;       // accepted, captured_valid

  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [VOL_W-1:0]     cfg_wdata = '0;

  audio_sample_ring_bridge dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow rings and registers
  sample_t          pb_mem  [RING_DEPTH];
  sample_t          cap_mem [RING_DEPTH];
  ptr_t             pb_wp = '0;
  ptr_t             pb_rp = '0;
  ptr_t             cap_wp = '0;
  ptr_t             cap_rp = '0;
  logic [VOL_W-1:0] vol_q = VOL_RESET;
  logic             play_en_q = 1'b0;
  logic             rec_en_q = 1'b0;
  logic             mute_q = 1'b0;

  bridge_cmd_t    cmd_q[$];
  bridge_result_t due_results[$];
  bridge_cmd_t    cur_cmd;
  bridge_result_t have, want;
  int             mismatches = 0;
  int             cycles = 0;
  int             in_gap = 0;
  int             in_calm = 0;
  int             out_stall = 0;
  int             out_calm = 0;

  // advance the shadow rings by one command and form its result
  function automatic bridge_result_t bridge_step(input op_t op, input sample_t s);
    bridge_result_t r;
    int             prod;
    ptr_t           fill;
    r = '0;
    case (op)
      OP_PUSH: begin
        prod = int'(s) * int'(vol_q) / PERCENT;
        fill = pb_wp - pb_rp;
        if (fill < RING_DEPTH) begin
          pb_mem[pb_wp[ADDR_W-1:0]] = sample_t'(prod);
          pb_wp++;
          r.accepted = 1'b1;
        end
      end
      OP_TICK: begin
        fill = pb_wp - pb_rp;
        if (play_en_q && !mute_q && fill != 0) begin
          r.left  = pb_mem[pb_rp[ADDR_W-1:0]];
          r.right = r.left;
          pb_rp++;
        end
      end
      OP_CAPTURE: begin
        fill = cap_wp - cap_rp;
        if (rec_en_q && fill < RING_DEPTH) begin
          cap_mem[cap_wp[ADDR_W-1:0]] = s;
          cap_wp++;
          r.accepted = 1'b1;
        end
      end
      OP_PULL: begin
        fill = cap_wp - cap_rp;
        if (fill != 0) begin
          r.captured       = cap_mem[cap_rp[ADDR_W-1:0]];
          r.captured_valid = 1'b1;
          cap_rp++;
        end
      end
      OP_CLR_PB: begin
        pb_wp = '0;
        pb_rp = '0;
      end
      OP_CLR_CAP: begin
        cap_wp = '0;
        cap_rp = '0;
      end
      default: ;
    endcase
    fill    = pb_wp - pb_rp;
    r.space = 16'(RING_DEPTH - int'(fill));
    fill    = cap_wp - cap_rp;
    r.count = 16'(fill);
    return r;
  endfunction

  // idle length: mostly none or short, a few long, with calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 200);
      return 0;
    end
    if (r < 72) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // sample values with a bias toward the extremes
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 15))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic cmp_field(input string name, input logic [15:0] exp_v,
                           input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // command driver: holds an item until its transfer, then picks a gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(bridge_step(cur_cmd.op, cur_cmd.sample));
        in_gap = pick_gap(in_calm);
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cur_cmd = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_cmd.op;
          in_tdata  <= cur_cmd.sample;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        have.left           = out_tdata[15:0];
        have.right          = out_tdata[31:16];
        have.captured       = out_tdata[47:32];
        have.space          = out_tdata[63:48];
        have.count          = out_tdata[79:64];
        have.accepted       = out_tuser[0];
        have.captured_valid = out_tuser[1];
        if (due_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          cmp_field("accepted", 16'(want.accepted), 16'(have.accepted));
          cmp_field("left_out", want.left, have.left);
          cmp_field("right_out", want.right, have.right);
          cmp_field("captured_sample", want.captured, have.captured);
          cmp_field("captured_valid", 16'(want.captured_valid),
                    16'(have.captured_valid));
          cmp_field("playback_space", want.space, have.space);
          cmp_field("capture_count", want.count, have.count);
        end
      end
      if (out_stall == 0 && ((out_tvalid && out_tready) || $urandom_range(0, 15) == 0))
        out_stall = pick_gap(out_calm);
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_cmd(input op_t op, input sample_t s);
    bridge_cmd_t c;
    c.op     = op;
    c.sample = s;
    cmd_q.push_back(c);
  endtask

  // block is idle once everything sent has come back
  task automatic wait_idle();
    do @(negedge clk); while (cmd_q.size() != 0 || in_tvalid || due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [VOL_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_VOLUME:  vol_q = (val < VOL_MIN) ? VOL_MIN : (val > VOL_MAX) ? VOL_MAX : val;
      REG_PLAY_EN: play_en_q = val[0];
      REG_REC_EN:  rec_en_q = val[0];
      REG_MUTE:    mute_q = val[0];
      default: ;
    endcase
  endtask

  initial begin
    int               r;
    op_t              op;
    logic [VOL_W-1:0] v;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: empty pull, tick while off, capture while disabled, pushes, spare opcodes
    queue_cmd(OP_PULL, 16'sh0000);
    queue_cmd(OP_TICK, 16'shffff);
    queue_cmd(OP_CAPTURE, 16'sh1234);
    queue_cmd(OP_PUSH, 16'sh7fff);
    queue_cmd(OP_PUSH, 16'sh8000);
    queue_cmd(OP_PUSH, 16'shffff);
    queue_cmd(OP_SPARE_6, 16'shffff);
    queue_cmd(OP_SPARE_7, 16'sh5a5a);
    queue_cmd(OP_TICK, 16'sh0000);
    wait_idle();

    // muted tick leaves the ring alone
    write_reg(REG_PLAY_EN, 7'd1);
    write_reg(REG_MUTE, 7'd1);
    queue_cmd(OP_TICK, 16'sh0000);
    wait_idle();

    // draining, capture, clears on non-empty rings
    write_reg(REG_MUTE, 7'd0);
    write_reg(REG_REC_EN, 7'd1);
    queue_cmd(OP_TICK, 16'sh0000);
    queue_cmd(OP_CAPTURE, 16'sh7fff);
    queue_cmd(OP_CAPTURE, 16'sh8000);
    queue_cmd(OP_PULL, 16'sh0000);
    queue_cmd(OP_PUSH, 16'sh0000);
    queue_cmd(OP_CLR_PB, 16'shffff);
    queue_cmd(OP_TICK, 16'sh0000);
    queue_cmd(OP_CLR_CAP, 16'shffff);
    queue_cmd(OP_PULL, 16'sh0000);
    wait_idle();

    // volume below and above range saturates, truncation toward zero
    write_reg(REG_VOLUME, 7'd0);
    queue_cmd(OP_PUSH, 16'sh8000);
    queue_cmd(OP_PUSH, 16'sh7fff);
    queue_cmd(OP_PUSH, 16'shffff);
    wait_idle();
    write_reg(REG_VOLUME, 7'd9);
    queue_cmd(OP_PUSH, 16'sh0064);
    wait_idle();
    write_reg(REG_VOLUME, 7'd127);
    queue_cmd(OP_PUSH, 16'shffff);
    queue_cmd(OP_TICK, 16'sh0000);
    queue_cmd(OP_TICK, 16'sh0000);
    wait_idle();

    // random phases, each under fresh register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: v = 7'd101;
        1: v = 7'd11;
        2: v = 7'd127;
        3: v = 7'd10;
        4: v = 7'd100;
        default: v = 7'($urandom_range(0, 127));
      endcase
      write_reg(REG_VOLUME, v);
      v = 7'($urandom_range(0, 127));
      v[0] = ($urandom_range(0, 3) != 0);
      write_reg(REG_PLAY_EN, v);
      v = 7'($urandom_range(0, 127));
      v[0] = ($urandom_range(0, 3) != 0);
      write_reg(REG_REC_EN, v);
      v = 7'($urandom_range(0, 127));
      v[0] = ($urandom_range(0, 4) == 0);
      write_reg(REG_MUTE, v);
      @(negedge clk);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 28) op = OP_PUSH;
        else if (r < 50) op = OP_TICK;
        else if (r < 72) op = OP_CAPTURE;
        else if (r < 94) op = OP_PULL;
        else if (r < 96) op = OP_CLR_PB;
        else if (r < 98) op = OP_CLR_CAP;
        else op = (r < 99) ? OP_SPARE_6 : OP_SPARE_7;
        queue_cmd(op, rand_sample());
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
